// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/mpd_pkg.sv -----
// Constants, widths and the arctangent table for the meters-per-degree pipeline.
package mpd_pkg;

  localparam int unsigned OUT_FRAC_BITS = 8;
  localparam int unsigned LAT_W         = 31;
  localparam int unsigned OUT_W         = 25;
  localparam int unsigned CORDIC_STEPS  = 31;
  localparam int unsigned XY_W          = 34;
  localparam int unsigned Z_W           = 33;
  localparam int unsigned OUT_SHIFT     = 46 - OUT_FRAC_BITS;

  localparam logic signed [LAT_W-1:0] LAT_LIMIT = 31'sd900000000;
  localparam logic [31:0] DEG7_TO_RAD      = 32'd4024455254;
  localparam logic [29:0] CORDIC_GAIN      = 30'd652032874;
  localparam logic [22:0] E2_Q30           = 23'd7188041;
  localparam logic [29:0] ONE_MINUS_E2_Q30 = 30'd1066553783;
  localparam logic [32:0] AR_Q16           = 33'd7295437580;
  localparam logic [OUT_W-1:0] OUT_MAX     = '1;

  typedef logic [31:0] quot_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/mpd_if.sv -----
// Valid/ready channel interfaces for latitude beats and result beats.
interface mpd_lat_if;
  logic                                valid;
  logic                                ready;
  logic signed [mpd_pkg::LAT_W-1:0]    latitude;
  modport source (output valid, output latitude, input ready);
  modport sink   (input valid, input latitude, output ready);
endinterface

interface mpd_res_if;
  logic                          valid;
  logic                          ready;
  logic [mpd_pkg::OUT_W-1:0]     meters_per_degree_latitude;
  logic [mpd_pkg::OUT_W-1:0]     meters_per_degree_longitude;
  modport source (output valid, output meters_per_degree_latitude,
                  output meters_per_degree_longitude, input ready);
  modport sink   (input valid, input meters_per_degree_latitude,
                  input meters_per_degree_longitude, output ready);
endinterface

// ----- rtl/core/mpd_cordic.sv -----
// Latitude clamp, conversion to Q2.30 radians and a one-step-per-stage CORDIC.
module mpd_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 vld_i,
  input  logic signed [mpd_pkg::LAT_W-1:0]     lat_i,
  output logic                                 vld_o,
  output logic signed [mpd_pkg::XY_W-1:0]      x_o,
  output logic signed [mpd_pkg::XY_W-1:0]      y_o
);

  localparam int unsigned N = mpd_pkg::CORDIC_STEPS;

  logic signed [mpd_pkg::LAT_W-1:0] lat_c;
  logic [mpd_pkg::LAT_W-1:0]        mag_full;
  logic                             neg;
  logic [61:0]                      prod_d;
  logic                             a_vld_q, a_neg_q;
  logic [61:0]                      a_prod_q;
  logic [61:0]                      zsum;
  logic signed [mpd_pkg::Z_W-1:0]   z0_d;

  logic                             v_q [N+1];
  logic signed [mpd_pkg::XY_W-1:0]  x_q [N+1];
  logic signed [mpd_pkg::XY_W-1:0]  y_q [N+1];
  logic signed [mpd_pkg::Z_W-1:0]   z_q [N+1];

  always_comb begin
    if (lat_i > mpd_pkg::LAT_LIMIT) begin
      lat_c = mpd_pkg::LAT_LIMIT;
    end else if (lat_i < -mpd_pkg::LAT_LIMIT) begin
      lat_c = -mpd_pkg::LAT_LIMIT;
    end else begin
      lat_c = lat_i;
    end
    neg      = lat_c[mpd_pkg::LAT_W-1];
    mag_full = neg ? mpd_pkg::LAT_W'(-lat_c) : mpd_pkg::LAT_W'(lat_c);
    prod_d   = 62'(mag_full[29:0]) * 62'(mpd_pkg::DEG7_TO_RAD);
  end

  always_comb begin
    zsum = a_prod_q + (62'(1) << 30);
    z0_d = a_neg_q ? -$signed(mpd_pkg::Z_W'(zsum[61:31]))
                   :  $signed(mpd_pkg::Z_W'(zsum[61:31]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      v_q[0]  <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
      v_q[0]  <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_neg_q  <= neg;
      a_prod_q <= prod_d;
      x_q[0]   <= $signed(mpd_pkg::XY_W'(mpd_pkg::CORDIC_GAIN));
      y_q[0]   <= '0;
      z_q[0]   <= z0_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [mpd_pkg::XY_W-1:0] xs, ys, x_d, y_d;
    logic signed [mpd_pkg::Z_W-1:0]  at, z_d;

    always_comb begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
      at = $signed(mpd_pkg::Z_W'(mpd_pkg::atan_q30(5'(i))));
      if (!z_q[i][mpd_pkg::Z_W-1]) begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - at;
      end else begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
      end
    end
  end

  assign vld_o = v_q[N];
  assign x_o   = x_q[N];
  assign y_o   = y_q[N];

endmodule

// ----- rtl/core/mpd_root.sv -----
// Clamp sine and cosine, form 1 - e^2 sin^2 and take its square root bit by bit.
module mpd_root (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 vld_i,
  input  logic signed [mpd_pkg::XY_W-1:0]      x_i,
  input  logic signed [mpd_pkg::XY_W-1:0]      y_i,
  output logic                                 vld_o,
  output logic [30:0]                          cos_o,
  output logic [30:0]                          d_o
);

  localparam int unsigned N = 31;

  logic signed [mpd_pkg::XY_W-1:0] ya;
  logic [30:0] c_d;
  logic [31:0] sa_d;
  logic        s1_vld_q, s2_vld_q, s3_vld_q;
  logic [30:0] s1_c_q, s2_c_q, s3_c_q;
  logic [31:0] s1_sa_q;
  logic [63:0] sq;
  logic [32:0] s2_q;
  logic [55:0] e2p;
  logic [25:0] e2s2;
  logic [30:0] dd_d, s3_dd_q;

  logic        v_q   [N+1];
  logic [30:0] c_q   [N+1];
  logic [30:0] r_q   [N+1];
  logic [61:0] rem_q [N+1];

  always_comb begin
    if (x_i[mpd_pkg::XY_W-1]) begin
      c_d = '0;
    end else if (x_i > $signed(mpd_pkg::XY_W'(1) << 30)) begin
      c_d = 31'(1) << 30;
    end else begin
      c_d = x_i[30:0];
    end
    ya = y_i[mpd_pkg::XY_W-1] ? -y_i : y_i;
    if (ya > $signed(mpd_pkg::XY_W'(1) << 31)) begin
      sa_d = 32'(1) << 31;
    end else begin
      sa_d = ya[31:0];
    end
  end

  always_comb begin
    sq   = 64'(s1_sa_q) * 64'(s1_sa_q) + (64'(1) << 29);
    e2p  = 56'(mpd_pkg::E2_Q30) * 56'(s2_q) + (56'(1) << 29);
    e2s2 = e2p[55:30];
    dd_d = (31'(e2s2) >= (31'(1) << 30)) ? '0 : (31'(1) << 30) - 31'(e2s2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_c_q  <= c_d;
      s1_sa_q <= sa_d;
      s2_c_q  <= s1_c_q;
      s2_q    <= sq[62:30];
      s3_c_q  <= s2_c_q;
      s3_dd_q <= dd_d;
    end
  end

  always_comb begin
    v_q[0]   = s3_vld_q;
    c_q[0]   = s3_c_q;
    r_q[0]   = '0;
    rem_q[0] = {1'b0, s3_dd_q, 30'b0};
  end

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam int unsigned B = N - 1 - k;
    logic [61:0] trial;
    logic        take;

    always_comb begin
      trial = (62'(r_q[k]) << (B + 1)) + (62'(1) << (2 * B));
      take  = rem_q[k] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        c_q[k+1]   <= c_q[k];
        r_q[k+1]   <= take ? (r_q[k] | (31'(1) << B)) : r_q[k];
        rem_q[k+1] <= take ? (rem_q[k] - trial) : rem_q[k];
      end
    end
  end

  assign vld_o = v_q[N];
  assign cos_o = c_q[N];
  assign d_o   = r_q[N];

endmodule

// ----- rtl/core/mpd_div.sv -----
// Cube of d and two restoring dividers, one quotient bit per stage.
module mpd_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  logic [30:0]          cos_i,
  input  logic [30:0]          d_i,
  output logic                 vld_o,
  output mpd_pkg::quot_t       ql_o,
  output mpd_pkg::quot_t       qm_o
);

  localparam int unsigned N = 32;

  logic [63:0] d2p, d3p;
  logic        a_vld_q, b_vld_q;
  logic [30:0] a_c_q, a_d_q, b_d_q;
  logic [1:0]  b_clo_q;
  logic [31:0] a_d2_q, b_d3_q;
  logic [32:0] b_reml;

  logic        v_q    [N+1];
  logic [1:0]  clo_q  [N+1];
  logic [31:0] dl_q   [N+1];
  logic [31:0] dm_q   [N+1];
  logic [32:0] reml_q [N+1];
  logic [32:0] remm_q [N+1];
  logic [31:0] ql_q   [N+1];
  logic [31:0] qm_q   [N+1];

  always_comb begin
    d2p    = 64'(d_i) * 64'(d_i) + (64'(1) << 29);
    d3p    = 64'(a_d2_q) * 64'(a_d_q) + (64'(1) << 29);
    b_reml = 33'(a_c_q[30:2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_c_q   <= cos_i;
      a_d_q   <= d_i;
      a_d2_q  <= d2p[61:30];
      b_d_q   <= a_d_q;
      b_clo_q <= a_c_q[1:0];
      b_d3_q  <= d3p[61:30];
      reml_q[0] <= b_reml;
    end
  end

  always_comb begin
    v_q[0]    = b_vld_q;
    clo_q[0]  = b_clo_q;
    dl_q[0]   = 32'(b_d_q);
    dm_q[0]   = b_d3_q;
    remm_q[0] = 33'(mpd_pkg::ONE_MINUS_E2_Q30[29:2]);
    ql_q[0]   = '0;
    qm_q[0]   = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam int unsigned B = N - 1 - k;
    logic [31:0] numl_lo, numm_lo;
    logic [32:0] tl, tm;
    logic        gl, gm;

    always_comb begin
      numl_lo = {clo_q[k], 30'b0};
      numm_lo = {mpd_pkg::ONE_MINUS_E2_Q30[1:0], 30'b0};
      tl = {reml_q[k][31:0], numl_lo[B]};
      tm = {remm_q[k][31:0], numm_lo[B]};
      gl = tl >= 33'(dl_q[k]);
      gm = tm >= 33'(dm_q[k]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        clo_q[k+1]  <= clo_q[k];
        dl_q[k+1]   <= dl_q[k];
        dm_q[k+1]   <= dm_q[k];
        reml_q[k+1] <= gl ? (tl - 33'(dl_q[k])) : tl;
        remm_q[k+1] <= gm ? (tm - 33'(dm_q[k])) : tm;
        ql_q[k+1]   <= {ql_q[k][30:0], gl};
        qm_q[k+1]   <= {qm_q[k][30:0], gm};
      end
    end
  end

  assign vld_o = v_q[N];
  assign ql_o  = ql_q[N];
  assign qm_o  = qm_q[N];

endmodule

// ----- rtl/core/mpd_scale.sv -----
// Scale both quotients by a*pi/180, round to nearest and saturate.
module mpd_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         vld_i,
  input  mpd_pkg::quot_t               ql_i,
  input  mpd_pkg::quot_t               qm_i,
  output logic                         vld_o,
  output logic [mpd_pkg::OUT_W-1:0]    lat_o,
  output logic [mpd_pkg::OUT_W-1:0]    lon_o
);

  localparam int unsigned SH = mpd_pkg::OUT_SHIFT;
  localparam int unsigned RW = 66 - SH;

  logic        a_vld_q, b_vld_q, c_vld_q;
  logic [48:0] a_mlo_q, a_mhi_q, a_llo_q, a_lhi_q;
  logic [65:0] sm_d, sl_d, b_sm_q, b_sl_q;
  logic [RW-1:0] rm, rl;
  logic [mpd_pkg::OUT_W-1:0] c_lat_q, c_lon_q;

  always_comb begin
    sm_d = (66'(a_mhi_q) << 16) + 66'(a_mlo_q) + (66'(1) << (SH - 1));
    sl_d = (66'(a_lhi_q) << 16) + 66'(a_llo_q) + (66'(1) << (SH - 1));
    rm   = RW'(b_sm_q >> SH);
    rl   = RW'(b_sl_q >> SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_mlo_q <= 49'(mpd_pkg::AR_Q16) * 49'(qm_i[15:0]);
      a_mhi_q <= 49'(mpd_pkg::AR_Q16) * 49'(qm_i[31:16]);
      a_llo_q <= 49'(mpd_pkg::AR_Q16) * 49'(ql_i[15:0]);
      a_lhi_q <= 49'(mpd_pkg::AR_Q16) * 49'(ql_i[31:16]);
      b_sm_q  <= sm_d;
      b_sl_q  <= sl_d;
      c_lat_q <= (rm > RW'(mpd_pkg::OUT_MAX)) ? mpd_pkg::OUT_MAX : mpd_pkg::OUT_W'(rm);
      c_lon_q <= (rl > RW'(mpd_pkg::OUT_MAX)) ? mpd_pkg::OUT_MAX : mpd_pkg::OUT_W'(rl);
    end
  end

  assign vld_o = c_vld_q;
  assign lat_o = c_lat_q;
  assign lon_o = c_lon_q;

endmodule

// ----- rtl/core/meters_per_degree_from_latitude.sv -----
// Throughput: one beat per cycle while the output is not stalled; the 31-stage CORDIC,
// the 31-stage square root and the 32-stage dividers each retire one item per cycle.
// The whole pipeline holds while a result beat waits at the output register.
// Reset clears only the valid bits; no result beat appears until an input is taken.
module meters_per_degree_from_latitude (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpd_lat_if.sink   in_i,
  mpd_res_if.source out_o
);

  logic adv;
  logic c_vld, r_vld, d_vld, s_vld;
  logic signed [mpd_pkg::XY_W-1:0] cx, cy;
  logic [30:0] r_cos, r_d;
  mpd_pkg::quot_t ql, qm;

  assign adv      = !s_vld || out_o.ready;
  assign in_i.ready = adv;

  mpd_cordic u_cordic (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(in_i.valid), .lat_i(in_i.latitude),
    .vld_o(c_vld), .x_o(cx), .y_o(cy)
  );

  mpd_root u_root (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(c_vld), .x_i(cx), .y_i(cy),
    .vld_o(r_vld), .cos_o(r_cos), .d_o(r_d)
  );

  mpd_div u_div (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(r_vld), .cos_i(r_cos), .d_i(r_d),
    .vld_o(d_vld), .ql_o(ql), .qm_o(qm)
  );

  mpd_scale u_scale (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(d_vld), .ql_i(ql), .qm_i(qm),
    .vld_o(s_vld), .lat_o(out_o.meters_per_degree_latitude),
    .lon_o(out_o.meters_per_degree_longitude)
  );

  assign out_o.valid = s_vld;

endmodule

// ----- rtl/core/mpd_checker.sv -----
// Port-level checks for the meters-per-degree block, bound to the top level.
`include "assert_macros.svh"

module mpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mpd_pkg::OUT_W-1:0]   out_lat_i,
  input logic [mpd_pkg::OUT_W-1:0]   out_lon_i
);

  // Input backpressure only comes from a waiting result beat.
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)
  // Every result carries a nonzero meridian length.
  `ASSERT_IMPLY(a_lat_nonzero, clk_i, rst_ni, out_valid_i, out_lat_i != '0)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_lat_i) && $stable(out_lon_i))

endmodule

bind meters_per_degree_from_latitude mpd_checker u_mpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_lat_i   (out_o.meters_per_degree_latitude),
  .out_lon_i   (out_o.meters_per_degree_longitude)
);

// ----- test/tb_meters_per_degree_from_latitude.sv -----
// Testbench for the meters-per-degree pipeline: predicts both lengths and checks every beat.
module tb_meters_per_degree_from_latitude;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mpd_pkg::OUT_W-1:0] lat_len;
    logic [mpd_pkg::OUT_W-1:0] lon_len;
  } lengths_t;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int unsigned ITEMS = 450;
  localparam longint CYCLE_LIMIT = 400000;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [mpd_pkg::OUT_W-1:0] to_meters(input longint unsigned q);
    longint unsigned r;
    r = (longint'(mpd_pkg::AR_Q16) * q + (64'd1 << (mpd_pkg::OUT_SHIFT - 1)))
        >> mpd_pkg::OUT_SHIFT;
    return (r > longint'(mpd_pkg::OUT_MAX)) ? mpd_pkg::OUT_MAX : r[mpd_pkg::OUT_W-1:0];
  endfunction

  function automatic lengths_t lengths_for(input logic signed [mpd_pkg::LAT_W-1:0] lat_in);
    longint lat, z, x, y, xs, ys, c;
    longint unsigned mag, sa, s2, e2s2, dd, d, ql, qm, d2, d3;
    logic neg;
    lengths_t res;
    lat = lat_in;
    if (lat > longint'(mpd_pkg::LAT_LIMIT)) lat = mpd_pkg::LAT_LIMIT;
    if (lat < -longint'(mpd_pkg::LAT_LIMIT)) lat = -longint'(mpd_pkg::LAT_LIMIT);
    neg = lat < 0;
    mag = neg ? -lat : lat;
    z = (mag * longint'(mpd_pkg::DEG7_TO_RAD) + (64'd1 << 30)) >> 31;
    if (neg) z = -z;
    x = mpd_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < mpd_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(mpd_pkg::atan_q30(5'(i)));
      end else begin
        x += ys; y -= xs; z += longint'(mpd_pkg::atan_q30(5'(i)));
      end
    end
    c = x;
    if (c < 0) c = 0;
    if (c > ONE_Q30) c = ONE_Q30;
    sa = (y < 0) ? -y : y;
    if (sa > 2 * ONE_Q30) sa = 2 * ONE_Q30;
    s2 = (sa * sa + (64'd1 << 29)) >> 30;
    e2s2 = (longint'(mpd_pkg::E2_Q30) * s2 + (64'd1 << 29)) >> 30;
    dd = (e2s2 >= ONE_Q30) ? 0 : ONE_Q30 - e2s2;
    d = int_sqrt(dd << 30);
    ql = 0;
    qm = 0;
    if (d != 0) ql = (longint'(c) << 30) / d;
    d2 = (d * d + (64'd1 << 29)) >> 30;
    d3 = (d2 * d + (64'd1 << 29)) >> 30;
    if (d3 != 0) qm = (longint'(mpd_pkg::ONE_MINUS_E2_Q30) << 30) / d3;
    if (qm > (64'd1 << 31)) qm = 64'd1 << 31;
    res.lat_len = to_meters(qm);
    res.lon_len = to_meters(ql);
    return res;
  endfunction

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class lengths_board;
    lengths_t pending[$];
    function void note_latitude(input logic signed [mpd_pkg::LAT_W-1:0] lat);
      pending.push_back(lengths_for(lat));
    endfunction
    task check_lengths(input logic [mpd_pkg::OUT_W-1:0] lat_len,
                       input logic [mpd_pkg::OUT_W-1:0] lon_len);
      lengths_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", lat_len, 0);
        return;
      end
      want = pending.pop_front();
      if (lat_len !== want.lat_len) report("latitude length", lat_len, want.lat_len);
      if (lon_len !== want.lon_len) report("longitude length", lon_len, want.lon_len);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  mpd_lat_if lat_ch();
  mpd_res_if res_ch();
  lengths_board board = new();

  meters_per_degree_from_latitude uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(lat_ch.sink), .out_o(res_ch.source)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (lat_ch.valid && lat_ch.ready) board.note_latitude(lat_ch.latitude);
      if (res_ch.valid && res_ch.ready)
        board.check_lengths(res_ch.meters_per_degree_latitude,
                            res_ch.meters_per_degree_longitude);
    end
  end

  logic calm = 0;     // no idling on either side
  logic hold_off = 0; // receiver stalls for a long stretch

  initial begin
    lat_ch.valid = 0;
    lat_ch.latitude = '0;
    res_ch.ready = 0;
  end

  // Receiver: random stalls, plus one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) res_ch.ready <= 0;
    else res_ch.ready <= calm || ($urandom_range(99) >= 27);
  end

  // Drop valid only while idling; back-to-back beats keep it high.
  task automatic send_latitude(input logic signed [mpd_pkg::LAT_W-1:0] lat);
    while (!calm && $urandom_range(99) < 27) begin
      lat_ch.valid <= 0;
      @(negedge clk_i);
    end
    lat_ch.valid <= 1;
    lat_ch.latitude <= lat;
    @(posedge clk_i);
    while (!lat_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [mpd_pkg::LAT_W-1:0] random_latitude();
    case ($urandom_range(9))
      0: return 31'($urandom);                             // any 31-bit pattern
      1: return ($urandom_range(1) ? 31'sd899999000 : -31'sd900000000) +
                $signed(31'($urandom_range(1000, 0)));
      default: return $signed(31'($urandom_range(1800000000))) - 31'sd900000000;
    endcase
  endfunction

  initial begin
    logic signed [mpd_pkg::LAT_W-1:0] directed[$];
    directed = {31'sd0, 31'sd1, -31'sd1, 31'sd900000000, -31'sd900000000,
                31'sd899999999, -31'sd899999999, 31'sd900000001, -31'sd900000001,
                31'sh3FFFFFFF, 31'sh40000000, 31'sd450000000, -31'sd450000000,
                31'sd300000000, -31'sd600000000, 31'sd123456789, 31'sh2AAAAAAA,
                31'sh55555555, 31'sd899990000, -31'sd899990000};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    foreach (directed[i]) send_latitude(directed[i]);
    for (int n = 0; n < ITEMS; n++) begin
      if (n == 100) calm <= 1;
      if (n == 180) calm <= 0;
      if (n == 250) begin
        hold_off <= 1;
        fork
          begin
            repeat (300) @(negedge clk_i);
            hold_off <= 0;
          end
        join_none
      end
      send_latitude(random_latitude());
    end
    lat_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- meters_per_degree_from_latitude.f -----
+incdir+rtl/core
rtl/core/mpd_pkg.sv
rtl/core/mpd_if.sv
rtl/core/mpd_cordic.sv
rtl/core/mpd_root.sv
rtl/core/mpd_div.sv
rtl/core/mpd_scale.sv
rtl/core/meters_per_degree_from_latitude.sv
rtl/core/mpd_checker.sv
test/tb_meters_per_degree_from_latitude.sv
